// ===== hw/rtl/hpkh_pkg.sv =====
`default_nettype none

package hpkh_pkg;

  localparam int unsigned AddrW     = 14;
  localparam int unsigned PackedW   = 4 * AddrW;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned HashW     = 16;
  localparam int unsigned KeyW      = 16;
  localparam int unsigned NumKeys   = 8;
  localparam int unsigned KeySelW   = $clog2(NumKeys);
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned AddrBytes = PackedW / ByteW;
  localparam int unsigned HashSteps = AddrBytes + 3;

  // Step index of the non-address bytes in hash order.
  localparam int unsigned StepLen   = AddrBytes;
  localparam int unsigned StepProto = AddrBytes + 1;

  typedef struct packed {
    logic [PackedW-1:0] addrs;
    logic [ByteW-1:0]   len;
    logic [ByteW-1:0]   proto;
  } hdr_t;

  // Byte fed into the hash at a given step; the sequence byte is always zero.
  function automatic logic [ByteW-1:0] step_byte(hdr_t hdr, int unsigned step);
    logic [ByteW-1:0] b;
    b = '0;
    if (step < AddrBytes) begin
      b = hdr.addrs[PackedW-1-ByteW*step -: ByteW];
    end else if (step == StepLen) begin
      b = hdr.len;
    end else if (step == StepProto) begin
      b = hdr.proto;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hpkh_cell.sv =====
`default_nettype none

// One hash step: add this step's byte, multiply by the key, keep the low word.
module hpkh_cell
  import hpkh_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [HashW-1:0] hash_i,
  input  wire hdr_t             hdr_i,
  input  wire logic [KeyW-1:0]  key_i,
  output logic                  valid_o,
  output logic [HashW-1:0]      hash_o,
  output hdr_t                  hdr_o
);

  logic [HashW-1:0]      sum;
  logic [HashW-1:0]      prod;
  logic                  valid_q;
  logic [HashW-1:0]      hash_q, hash_d;
  hdr_t                  hdr_q;

  // Only the low word of the product is kept, so multiply at hash width.
  always_comb begin
    sum    = hash_i + HashW'(step_byte(hdr_i, STEP));
    prod   = sum * key_i;
    hash_d = prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload advances every cycle; valid qualifies it.
  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    hdr_q  <= hdr_i;
  end

  assign valid_o = valid_q;
  assign hash_o  = hash_q;
  assign hdr_o   = hdr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/header_pack_keyed_hash_unit.sv =====
`default_nettype none

// Header pack and keyed hash. Each start request carries four 14-bit
// addresses, a length byte and a protocol byte. The addresses are packed
// MSB first into 56 bits, and a 16-bit hash runs over the seven address
// bytes, length, protocol and a zero sequence byte: h = (h + byte) * key,
// mod 65536, with key word (step mod KEY_COUNT). A row of ten cells, one per
// hash byte, each with one 16x16 multiplier and a register, carries the
// request forward, so a request is taken every cycle (busy is always low)
// and its result shows on done_o from the last cell's register, for
// one cycle only. The receiver cannot stall: sample the result when done_o
// is high. Write keys only while no request is in flight; writes to indexes
// above 7 are dropped. All keys reset to 1.
module header_pack_keyed_hash_unit
  import hpkh_pkg::*;
#(
  parameter int unsigned KEY_COUNT = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [AddrW-1:0]   dest_link_addr_i,
  input  wire logic [AddrW-1:0]   src_link_addr_i,
  input  wire logic [AddrW-1:0]   dest_net_addr_i,
  input  wire logic [AddrW-1:0]   src_net_addr_i,
  input  wire logic [ByteW-1:0]   payload_length_i,
  input  wire logic [ByteW-1:0]   protocol_number_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [KeyW-1:0]    cfg_wdata_i,
  output logic                    done_o,
  output logic [PackedW-1:0]      packed_addresses_o,
  output logic [ByteW-1:0]        length_out_o,
  output logic [ByteW-1:0]        protocol_out_o,
  output logic [ByteW-1:0]        sequence_out_o,
  output logic [HashW-1:0]        header_mac_o
);

  // Treat a key count below one as one.
  localparam int unsigned KeyCnt = (KEY_COUNT < 1) ? 1 : KEY_COUNT;

  logic [NumKeys-1:0][KeyW-1:0] key_q;

  // Chain taps: tap 0 is the incoming request, tap s+1 the output of cell s.
  logic                 tap_valid [HashSteps+1];
  logic [HashW-1:0]     tap_hash  [HashSteps+1];
  hdr_t                 tap_hdr   [HashSteps+1];

  // Key registers: hold unless written; drop writes beyond the key file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        key_q[k] <= KeyW'(1);
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumKeys))) begin
      key_q[cfg_idx_i[KeySelW-1:0]] <= cfg_wdata_i;
    end
  end

  // Every cycle is open for a new request.
  assign busy = 1'b0;

  // Pack the addresses MSB first and start the hash at zero.
  assign tap_valid[0]     = start & ~busy;
  assign tap_hash[0]      = '0;
  assign tap_hdr[0].addrs = {dest_link_addr_i, src_link_addr_i,
                             dest_net_addr_i, src_net_addr_i};
  assign tap_hdr[0].len   = payload_length_i;
  assign tap_hdr[0].proto = protocol_number_i;

  for (genvar s = 0; s < HashSteps; s++) begin : g_cell
    localparam int unsigned Slot = (s % KeyCnt) % NumKeys;

    hpkh_cell #(
      .STEP (s)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (tap_valid[s]),
      .hash_i  (tap_hash[s]),
      .hdr_i   (tap_hdr[s]),
      .key_i   (key_q[Slot]),
      .valid_o (tap_valid[s+1]),
      .hash_o  (tap_hash[s+1]),
      .hdr_o   (tap_hdr[s+1])
    );
  end

  // Present the result straight from the last cell.
  assign done_o             = tap_valid[HashSteps];
  assign packed_addresses_o = tap_hdr[HashSteps].addrs;
  assign length_out_o       = tap_hdr[HashSteps].len;
  assign protocol_out_o     = tap_hdr[HashSteps].proto;
  assign sequence_out_o     = '0;
  assign header_mac_o       = tap_hash[HashSteps];

  // Every accepted request comes out at the end of the cell chain.
  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##HashSteps done_o)
    else $error("request not delivered after the cell chain latency");

  // No result without a matching request that entered the cell chain.
  a_done_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, HashSteps))
    else $error("result without a matching request");

  // Writes beyond the key file leave the keys untouched.
  a_cfg_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i >= CfgIdxW'(NumKeys))) |=> $stable(key_q))
    else $error("out-of-range key write changed the keys");

endmodule

`default_nettype wire
